// ===== design/mis_pkg.sv =====
`default_nettype none
package mis_pkg;

  localparam int CAPACITY = 64;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VALUE_W  = 32;

  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic [CNT_W-1:0]          count_t;

  // Controls that are common to every cell of the row.
  typedef struct packed {
    logic insert_en;
    logic drain_en;
  } cell_ctl_t;

  // Where one cell stands relative to the current fill of the row.
  typedef struct packed {
    logic occupied;
    logic at_end;
  } cell_pos_t;

endpackage
`default_nettype wire

// ===== design/mis_cell.sv =====
`default_nettype none
module mis_cell (
  input  wire                      clk,
  input  mis_pkg::cell_ctl_t       ctl,
  input  mis_pkg::cell_pos_t       pos,
  input  mis_pkg::value_t          new_value,
  input  mis_pkg::value_t          left_value,
  input  wire                      left_gt,
  input  mis_pkg::value_t          right_value,
  output mis_pkg::value_t          held,
  output logic                     gt
);

  logic take;

  assign gt   = pos.occupied && (held > new_value);
  assign take = gt || pos.at_end;

  // On insert, a cell whose value is greater than the new word moves one place up,
  // so it takes the left neighbor's value when that one moves too, else the new word.
  always_ff @(posedge clk) begin
    if (ctl.insert_en && take) begin
      held <= left_gt ? left_value : new_value;
    end else if (ctl.drain_en) begin
      held <= right_value;
    end
  end

endmodule
`default_nettype wire

// ===== design/merge_insertion_sorter.sv =====
// Loading: one word accepted per cycle, each inserted into the sorted cell row.
// A word marked last closes the set; the row then drains, with results registered from cell 0.
// Results then leave one per cycle from cell 0, while out_stall allows, as the row shifts
// down; input stalls (in_stall) while the row drains.
// Reset (rst, synchronous) clears the fill count, overflow flag, state and output valid;
// cell contents are not reset.
`default_nettype none
module merge_insertion_sorter (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  wire signed [31:0]    value,
  input  wire                  last,
  output logic                 out_valid,
  input  wire                  out_stall,
  output logic signed [31:0]   value_res,
  output logic                 last_res,
  output logic                 dropped
);

  typedef enum logic {ST_LOAD, ST_DRAIN} state_t;

  state_t               state;
  mis_pkg::count_t      count;
  logic                 overflow;
  mis_pkg::cell_ctl_t   ctl;
  mis_pkg::value_t      held_a [mis_pkg::CAPACITY];
  logic                 gt_a   [mis_pkg::CAPACITY];
  logic                 in_acc;
  logic                 full;
  logic                 out_free;

  assign in_stall = (state == ST_DRAIN);
  assign in_acc   = in_valid && !in_stall;
  assign full     = (count == mis_pkg::count_t'(mis_pkg::CAPACITY));
  assign out_free = !out_valid || !out_stall;

  assign ctl.insert_en = in_acc && !full;
  assign ctl.drain_en  = (state == ST_DRAIN) && out_free;

  for (genvar i = 0; i < mis_pkg::CAPACITY; i++) begin : g_cell
    mis_pkg::cell_pos_t pos;
    mis_pkg::value_t    left_value;
    mis_pkg::value_t    right_value;
    logic               left_gt;

    assign pos.occupied = mis_pkg::count_t'(i) < count;
    assign pos.at_end   = mis_pkg::count_t'(i) == count;

    if (i == 0) begin : g_first
      assign left_value = held_a[0];
      assign left_gt    = 1'b0;
    end else begin : g_mid
      assign left_value = held_a[i-1];
      assign left_gt    = gt_a[i-1];
    end

    if (i == mis_pkg::CAPACITY - 1) begin : g_top
      assign right_value = held_a[i];
    end else begin : g_below
      assign right_value = held_a[i+1];
    end

    mis_cell u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .pos         (pos),
      .new_value   (value),
      .left_value  (left_value),
      .left_gt     (left_gt),
      .right_value (right_value),
      .held        (held_a[i]),
      .gt          (gt_a[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_LOAD;
      count     <= '0;
      overflow  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_LOAD: begin
          if (in_acc) begin
            if (full) begin
              overflow <= 1'b1;
            end else begin
              count <= count + 1'b1;
            end
            if (last) begin
              state <= ST_DRAIN;
            end
          end
        end
        ST_DRAIN: begin
          // The row never drains empty: a closed set always holds at least one word.
          if (out_free) begin
            out_valid <= 1'b1;
            value_res <= held_a[0];
            last_res  <= (count == mis_pkg::count_t'(1));
            dropped   <= overflow;
            count     <= count - 1'b1;
            if (count == mis_pkg::count_t'(1)) begin
              overflow <= 1'b0;
              state    <= ST_LOAD;
            end
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
module testbench;

  localparam int ITEM_TARGET = 430;
  localparam int LIMIT_CYCLES = 200000;
  localparam int HOLD_CYCLES = 400;
  localparam int HOLD_AT_WORD = 120;
  localparam int CALM_FROM = 250;
  localparam int CALM_TO = 330;
  localparam int DRAIN_SLACK = 20;
  localparam int IDLE_PCT = 18;
  localparam mis_pkg::value_t VMAX = 32'sh7fff_ffff;
  localparam mis_pkg::value_t VMIN = 32'sh8000_0000;

  typedef struct {
    mis_pkg::value_t value;
    bit              last;
    bit              dropped;
  } sorted_word_t;

  // Keeps the set being loaded in ascending order and, on a closing word,
  // queues the whole sorted run that the block must return.
  class sort_scoreboard;
    mis_pkg::value_t held[$];
    bit              overflow = 1'b0;
    sorted_word_t    pending[$];
    int              errors = 0;
    int              accepted = 0;

    task report(string msg);
      if (errors < 50) $display("mismatch at %0t: %s", $time, msg);
      errors++;
    endtask

    function void note_word(mis_pkg::value_t v, bit is_last);
      int           pos;
      sorted_word_t w;
      accepted++;
      if (held.size() < mis_pkg::CAPACITY) begin
        pos = held.size();
        while (pos > 0 && held[pos-1] > v) pos--;
        held.insert(pos, v);
      end else begin
        overflow = 1'b1;
      end
      if (is_last) begin
        foreach (held[i]) begin
          w.value = held[i];
          w.last = (i == held.size() - 1);
          w.dropped = overflow;
          pending.insert(pending.size(), w);
        end
        held.delete();
        overflow = 1'b0;
      end
    endfunction

    task check_word(mis_pkg::value_t v, bit l, bit d);
      sorted_word_t w;
      if (pending.size() == 0) begin
        report($sformatf("unexpected word value=%0d last=%0b dropped=%0b", v, l, d));
      end else begin
        w = pending.pop_front();
        if (v !== w.value) report($sformatf("value %0d, wanted %0d", v, w.value));
        if (l !== w.last) report($sformatf("last_res %0b, wanted %0b", l, w.last));
        if (d !== w.dropped) report($sformatf("dropped %0b, wanted %0b", d, w.dropped));
      end
    endtask
  endclass

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            in_valid = 1'b0;
  logic            in_stall;
  mis_pkg::value_t value = '0;
  logic            last = 1'b0;
  logic            out_valid;
  logic            out_stall = 1'b0;
  mis_pkg::value_t value_res;
  logic            last_res;
  logic            dropped;

  sort_scoreboard sb = new;
  bit calm = 1'b0;
  bit hold_req = 1'b0;
  int cycle_count = 0;

  merge_insertion_sorter DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .value(value),
    .last(last),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .value_res(value_res),
    .last_res(last_res),
    .dropped(dropped)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_word(value_res, last_res, dropped);
  end

  // Receiver: random stalls, plus one long hold-off so that the block has to stall its
  // input while it cannot drain.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  function automatic mis_pkg::value_t rand_value();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 55) return mis_pkg::value_t'($urandom);
    if (r < 70) return mis_pkg::value_t'($urandom_range(8)) - 4;
    if (r < 80) begin
      case ($urandom_range(4))
        0: return VMIN;
        1: return VMAX;
        2: return 0;
        3: return -1;
        default: return 1;
      endcase
    end
    if (r < 90) return VMAX - mis_pkg::value_t'($urandom_range(3));
    return VMIN + mis_pkg::value_t'($urandom_range(3));
  endfunction

  // Most sets are small; a few fill the row exactly or run past it.
  function automatic int pick_set_size(int idx);
    int unsigned r;
    if (idx == 2) return mis_pkg::CAPACITY;
    if (idx == 6) return mis_pkg::CAPACITY + 1;
    if (idx == 10) return mis_pkg::CAPACITY + 8;
    r = $urandom_range(99);
    if (r < 70) return $urandom_range(8, 1);
    if (r < 92) return $urandom_range(40, 9);
    if (r < 96) return mis_pkg::CAPACITY - 1;
    return $urandom_range(3, 1);
  endfunction

  task send_word(mis_pkg::value_t v, bit is_last);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    value <= v;
    last <= is_last;
    do @(posedge clk); while (in_stall);
    sb.note_word(v, is_last);
    if (sb.accepted == HOLD_AT_WORD) hold_req = 1'b1;
    calm = (sb.accepted >= CALM_FROM) && (sb.accepted < CALM_TO);
  endtask

  task send_random_set(int n);
    for (int i = 0; i < n; i++) send_word(rand_value(), i == n - 1);
  endtask

  initial begin
    int set_idx;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Single-word sets at both extremes.
    send_word(VMAX, 1'b1);
    send_word(VMIN, 1'b1);
    send_word(VMAX, 1'b0);
    send_word(VMIN, 1'b0);
    send_word(0, 1'b0);
    send_word(-1, 1'b0);
    send_word(1, 1'b1);
    // Repeated values.
    send_word(5, 1'b0);
    send_word(-3, 1'b0);
    send_word(5, 1'b0);
    send_word(-3, 1'b0);
    send_word(5, 1'b1);
    // Descending, then already ascending.
    send_word(3, 1'b0);
    send_word(2, 1'b0);
    send_word(1, 1'b0);
    send_word(0, 1'b0);
    send_word(-1, 1'b0);
    send_word(-2, 1'b1);
    send_word(VMIN, 1'b0);
    send_word(VMIN + 1, 1'b0);
    send_word(-1, 1'b0);
    send_word(0, 1'b0);
    send_word(VMAX - 1, 1'b0);
    send_word(VMAX, 1'b1);

    set_idx = 0;
    while (sb.accepted < ITEM_TARGET) begin
      send_random_set(pick_set_size(set_idx));
      set_idx++;
    end
    in_valid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_SLACK) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
